/* hw/rtl/bbs_pkg.sv */
// Shared field widths, kind codes, controller states and command/status bundles.
package bbs_pkg;

    localparam int KIND_W = 2;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic [KIND_W-1:0] K_WRITE  = 2'd0;
    localparam logic [KIND_W-1:0] K_READ   = 2'd1;
    localparam logic [KIND_W-1:0] K_PEEK   = 2'd2;
    localparam logic [KIND_W-1:0] K_REMOVE = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RD_ISSUE,
        S_RD_EMIT,
        S_MV_RD,
        S_MV_WR
    } t_state;

    typedef struct packed {
        logic in_load;      // latch the accepted input beat
        logic exec_write;   // apply one write byte and post its result
        logic exec_single;  // post the single result of read/peek/remove
        logic rd_start;     // clear byte counter for a multi-byte read
        logic rd_issue;     // issue store read of the next byte
        logic rd_emit;      // post the byte just read
        logic rd_consume;   // drop the bytes of a finished read
        logic mv_rd;        // relocation: read source byte
        logic mv_wr;        // relocation: write destination byte
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic is_read;
        logic rd_multi;     // read/peek that returns data bytes
        logic mv_need;      // pending consume leaves B to be relocated
        logic out_free;     // output register can take a beat this cycle
        logic rd_last;      // current byte is the final one
        logic mv_last;      // current relocation byte is the final one
    } t_stat;

endpackage

/* hw/rtl/bbs_in_if.sv */
// Input channel: one beat per write byte or command.
interface bbs_in_if;
    import bbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_in;

    modport source (output valid, output kind, output length, output data_in, input ready);
    modport sink   (input valid, input kind, input length, input data_in, output ready);
endinterface

/* hw/rtl/bbs_out_if.sv */
// Output channel: one beat per result item.
interface bbs_out_if;
    import bbs_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              last;

    modport source (output valid, output status, output data_out, output data_valid,
                    output last, input ready);
    modport sink   (input valid, input status, input data_out, input data_valid,
                    input last, output ready);
endinterface

/* hw/rtl/bip_buffer_byte_store_top.sv */
// Top level of the bip buffer byte store: controller plus datapath.
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   kind[1:0], length[6:0], data_in[7:0]
//  o_out    out  valid/ready   status, data_out[7:0], data_valid, last
//
// Each input beat is latched in S_IDLE and executed in S_EXEC, which holds while the
// output register is full; a write byte, remove, peek/read refusal or zero-length
// request posts its single result there. A read or peek of n bytes does one store read
// and one output load per byte, through the single registered read port.
// When a read or remove empties region A while B still holds m bytes behind its
// consumed head, B is copied down to offset zero, one store read and write per byte.
// Reset (i_rst_n low, synchronous) empties both regions at once; the store
// contents stay undefined and need no clearing pass.
// A new beat is taken while the last result still waits; o_out stalls only hold
// the sequencer where the next result would need the output register.
module bip_buffer_byte_store_top #(
    parameter int CAPACITY  = 4096,
    parameter int MAX_CHUNK = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbs_in_if.sink    i_in,
    bbs_out_if.source o_out
);
    import bbs_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer: accepts beats only when idle
    bbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // pointers, byte store and output register
    bbs_datapath #(
        .CAPACITY  (CAPACITY),
        .MAX_CHUNK (MAX_CHUNK)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_in.kind),
        .i_length     (i_in.length),
        .i_data_in    (i_in.data_in),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_status     (o_out.status),
        .o_data_out   (o_out.data_out),
        .o_data_valid (o_out.data_valid),
        .o_last       (o_out.last)
    );

    assign i_in.ready = in_ready;
endmodule

/* hw/rtl/bbs_ram.sv */
// Byte store: one write port, one read port with registered read data.
module bbs_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bbs_pkg::BYTE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bbs_pkg::BYTE_W-1:0] o_rdata
);
    import bbs_pkg::*;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/bbs_datapath.sv */
// Region pointers, chunk tracking, address generation, byte store and output register.
module bbs_datapath #(
    parameter int CAPACITY  = 4096,
    parameter int MAX_CHUNK = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbs_pkg::t_cmd              i_cmd,
    output bbs_pkg::t_stat             o_stat,
    input  logic [bbs_pkg::KIND_W-1:0] i_kind,
    input  logic [bbs_pkg::LEN_W-1:0]  i_length,
    input  logic [bbs_pkg::BYTE_W-1:0] i_data_in,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_status,
    output logic [bbs_pkg::BYTE_W-1:0] o_data_out,
    output logic                       o_data_valid,
    output logic                       o_last
);
    import bbs_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = AW + 1;
    localparam int CW = (SW > LEN_W) ? SW : LEN_W;
    localparam int XW = SW + 1;
    localparam logic [SW-1:0]    CAP_S = SW'(CAPACITY);
    localparam logic [LEN_W-1:0] MAXC  = LEN_W'(MAX_CHUNK);

    // latched input beat
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_len;
    logic [BYTE_W-1:0] r_data;

    // region and chunk state
    logic [AW-1:0]    r_a_start;
    logic [SW-1:0]    r_a_size;
    logic             r_b_active;
    logic [SW-1:0]    r_b_size;
    logic [LEN_W-1:0] r_chunk_rem;
    logic             r_chunk_acc;
    logic             r_chunk_b;

    // read and relocation counters
    logic [LEN_W-1:0] r_k;
    logic [LEN_W-1:0] r_mv_src;
    logic [AW-1:0]    r_mv_cnt;
    logic [AW-1:0]    r_mv_i;

    // output register
    logic              r_ov;
    logic              r_st;
    logic [BYTE_W-1:0] r_dout;
    logic              r_dv;
    logic              r_last;

    logic [BYTE_W-1:0] rdata;

    logic [SW-1:0] stored;
    logic [SW-1:0] free_a;
    logic [SW-1:0] a_end;
    logic          open_b;
    logic          oversize;

    logic             wr_acc;
    logic             wr_b;
    logic [LEN_W-1:0] wr_rem;
    logic             wr_bact;
    logic [SW-1:0]    wr_bsize;
    logic             wr_store;
    logic             wr_early;
    logic [SW-1:0]    wr_free;
    logic [AW-1:0]    wr_addr;

    logic rd_ref;
    logic single_st;
    logic cons_en;

    logic [LEN_W-1:0] cons_n;
    logic [LEN_W-1:0] from_a;
    logic [LEN_W-1:0] rem_n;
    logic [LEN_W-1:0] from_b;
    logic [SW-1:0]    na_size;
    logic [AW-1:0]    na_start;
    logic [SW-1:0]    nb_size;
    logic             a_empty;
    logic             cons_mv;
    logic             cons_go;

    logic [SW-1:0] rd_a_pos;
    logic [CW-1:0] rd_b_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] mv_raddr;
    logic          rd_last;
    logic          mv_last;

    logic              out_free;
    logic              out_load;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    assign stored   = r_a_size + r_b_size;
    assign a_end    = SW'(r_a_start) + r_a_size;
    assign free_a   = CAP_S - a_end;
    assign open_b   = free_a < SW'(r_a_start);
    assign oversize = r_len > MAXC;

    // write byte: placement decision on the first byte of a chunk
    always_comb begin
        wr_acc   = r_chunk_acc;
        wr_b     = r_chunk_b;
        wr_rem   = r_chunk_rem;
        wr_bact  = r_b_active;
        wr_bsize = r_b_size;
        wr_early = 1'b0;
        wr_free  = '0;
        wr_store = 1'b0;
        if (r_chunk_rem == '0) begin
            if (oversize) begin
                wr_acc   = 1'b0;
                wr_b     = 1'b0;
                wr_rem   = r_len - LEN_W'(1);
                wr_early = 1'b1;
            end else begin
                if (r_b_active) begin
                    wr_free = SW'(r_a_start) - r_b_size;
                    wr_b    = 1'b1;
                end else if (open_b) begin
                    wr_bact  = 1'b1;
                    wr_bsize = '0;
                    wr_free  = SW'(r_a_start);
                    wr_b     = 1'b1;
                end else begin
                    wr_free = free_a;
                    wr_b    = 1'b0;
                end
                wr_acc = CW'(r_len) <= CW'(wr_free);
                if (r_len == '0) begin
                    wr_rem   = '0;
                    wr_early = 1'b1;
                end else begin
                    wr_rem = r_len;
                end
            end
        end
        if (!wr_early) begin
            wr_store = wr_acc;
            wr_rem   = wr_rem - LEN_W'(1);
        end
    end

    assign wr_addr = wr_b ? wr_bsize[AW-1:0] : a_end[AW-1:0];

    // read/peek refusal and single-result handling
    assign rd_ref    = oversize || (CW'(r_len) > CW'(stored));
    assign single_st = ((r_kind == K_READ) || (r_kind == K_PEEK)) ? rd_ref : 1'b0;
    assign cons_en   = (r_kind == K_REMOVE) || ((r_kind == K_READ) && !rd_ref);

    // consume: A first, then B; A-empty rule
    assign cons_n   = ((r_kind == K_REMOVE) && (CW'(r_len) > CW'(stored)))
                      ? LEN_W'(stored) : r_len;
    assign from_a   = (CW'(cons_n) > CW'(r_a_size)) ? LEN_W'(r_a_size) : cons_n;
    assign na_size  = r_a_size - SW'(from_a);
    assign na_start = r_a_start + AW'(from_a);
    assign rem_n    = cons_n - from_a;
    assign from_b   = (CW'(rem_n) > CW'(r_b_size)) ? LEN_W'(r_b_size) : rem_n;
    assign nb_size  = r_b_size - SW'(from_b);
    assign a_empty  = (na_size == '0);
    assign cons_mv  = a_empty && (nb_size != '0) && (from_b != '0);
    assign cons_go  = (i_cmd.exec_single && cons_en) || i_cmd.rd_consume;

    // byte addresses: A bytes first, then B from offset zero
    assign rd_a_pos = SW'(r_a_start) + SW'(r_k);
    assign rd_b_pos = CW'(r_k) - CW'(r_a_size);
    assign rd_addr  = (CW'(r_k) < CW'(r_a_size)) ? rd_a_pos[AW-1:0] : rd_b_pos[AW-1:0];
    assign rd_last  = (r_k + LEN_W'(1)) == r_len;
    assign mv_raddr = r_mv_i + AW'(r_mv_src);
    assign mv_last  = (r_mv_i + AW'(1)) == r_mv_cnt;

    assign out_free = !r_ov || i_out_ready;
    assign out_load = i_cmd.exec_write || i_cmd.exec_single || i_cmd.rd_emit;

    assign mem_we    = (i_cmd.exec_write && wr_store) || i_cmd.mv_wr;
    assign mem_waddr = i_cmd.mv_wr ? r_mv_i : wr_addr;
    assign mem_wdata = i_cmd.mv_wr ? rdata : r_data;
    assign mem_re    = i_cmd.rd_issue || i_cmd.mv_rd;
    assign mem_raddr = i_cmd.mv_rd ? mv_raddr : rd_addr;

    bbs_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_start   <= '0;
            r_a_size    <= '0;
            r_b_active  <= 1'b0;
            r_b_size    <= '0;
            r_chunk_rem <= '0;
            r_chunk_acc <= 1'b0;
            r_chunk_b   <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.exec_write) begin
                r_chunk_acc <= wr_acc;
                r_chunk_b   <= wr_b;
                r_chunk_rem <= wr_rem;
                r_b_active  <= wr_bact;
                r_b_size    <= (wr_store && wr_b) ? wr_bsize + SW'(1) : wr_bsize;
                if (wr_store && !wr_b) begin
                    r_a_size <= r_a_size + SW'(1);
                end
            end
            if (i_cmd.exec_single || i_cmd.rd_start) begin
                r_chunk_rem <= '0;
            end
            if (cons_go) begin
                if (a_empty) begin
                    r_a_size   <= nb_size;
                    r_a_start  <= '0;
                    r_b_active <= 1'b0;
                    r_b_size   <= '0;
                end else begin
                    r_a_size  <= na_size;
                    r_a_start <= na_start;
                end
            end
        end
    end

    // payload and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_kind <= i_kind;
            r_len  <= i_length;
            r_data <= i_data_in;
        end
        if (i_cmd.rd_start) begin
            r_k <= '0;
        end else if (i_cmd.rd_emit) begin
            r_k <= r_k + LEN_W'(1);
        end
        if (cons_go && cons_mv) begin
            r_mv_src <= from_b;
            r_mv_cnt <= nb_size[AW-1:0];
            r_mv_i   <= '0;
        end else if (i_cmd.mv_wr) begin
            r_mv_i <= r_mv_i + AW'(1);
        end
        if (i_cmd.exec_write) begin
            r_st   <= !wr_acc;
            r_dout <= '0;
            r_dv   <= 1'b0;
            r_last <= 1'b1;
        end else if (i_cmd.exec_single) begin
            r_st   <= single_st;
            r_dout <= '0;
            r_dv   <= 1'b0;
            r_last <= 1'b1;
        end else if (i_cmd.rd_emit) begin
            r_st   <= 1'b0;
            r_dout <= rdata;
            r_dv   <= 1'b1;
            r_last <= rd_last;
        end
    end

    always_comb begin
        o_stat.is_write = (r_kind == K_WRITE);
        o_stat.is_read  = (r_kind == K_READ);
        o_stat.rd_multi = ((r_kind == K_READ) || (r_kind == K_PEEK)) && !rd_ref
                          && (r_len != '0);
        o_stat.mv_need  = cons_mv && cons_en;
        o_stat.out_free = out_free;
        o_stat.rd_last  = rd_last;
        o_stat.mv_last  = mv_last;
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_st;
    assign o_data_out   = r_dout;
    assign o_data_valid = r_dv;
    assign o_last       = r_last;

`ifndef ASSERT_OFF
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_a_size) + XW'(r_b_size)) <= XW'(CAPACITY))
        else $error("stored byte count exceeds capacity");

    a_b_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_active ? (SW'(r_a_start) >= r_b_size) : (r_b_size == '0))
        else $error("region B overlaps region A or is nonzero while inactive");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten before its beat was taken");
`endif
endmodule

/* hw/rtl/bbs_ctrl.sv */
// Sequencing state machine: dispatch, byte-by-byte reads, region relocation.
module bbs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bbs_pkg::t_stat i_stat,
    output bbs_pkg::t_cmd  o_cmd
);
    import bbs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.is_write) begin
                    if (i_stat.out_free) n_state = S_IDLE;
                end else if (i_stat.rd_multi) begin
                    n_state = S_RD_ISSUE;
                end else if (i_stat.out_free) begin
                    n_state = i_stat.mv_need ? S_MV_RD : S_IDLE;
                end
            end
            S_RD_ISSUE: n_state = S_RD_EMIT;
            S_RD_EMIT: begin
                if (i_stat.out_free) begin
                    if (!i_stat.rd_last) begin
                        n_state = S_RD_ISSUE;
                    end else if (i_stat.is_read && i_stat.mv_need) begin
                        n_state = S_MV_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MV_RD: n_state = S_MV_WR;
            S_MV_WR: begin
                if (i_stat.mv_last) n_state = S_IDLE;
                else                n_state = S_MV_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.in_load = i_in_valid;
            end
            S_EXEC: begin
                if (i_stat.is_write) begin
                    o_cmd.exec_write = i_stat.out_free;
                end else if (i_stat.rd_multi) begin
                    o_cmd.rd_start = 1'b1;
                end else begin
                    o_cmd.exec_single = i_stat.out_free;
                end
            end
            S_RD_ISSUE: o_cmd.rd_issue = 1'b1;
            S_RD_EMIT: begin
                o_cmd.rd_emit    = i_stat.out_free;
                o_cmd.rd_consume = i_stat.out_free && i_stat.rd_last && i_stat.is_read;
            end
            S_MV_RD: o_cmd.mv_rd = 1'b1;
            S_MV_WR: o_cmd.mv_wr = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule

/* tb/bip_store_check_pkg.sv */
// Scoreboard class that predicts and checks the result beats of the bip buffer byte store.
package bip_store_check_pkg;
    import bbs_pkg::*;

    // Small store so that region B opens and moves down often within a short run.
    localparam int unsigned STORE_BYTES = 128;
    localparam int unsigned CHUNK_MAX   = 64;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic              last;
    } t_store_result;

    class byte_store_scoreboard;
        logic [BYTE_W-1:0] mem [STORE_BYTES];
        int unsigned       a_start;
        int unsigned       a_size;
        int unsigned       b_size;
        bit                b_active;
        int unsigned       chunk_left;
        bit                chunk_ok;
        bit                chunk_to_b;
        t_store_result     awaited[$];
        int unsigned       errors;
        int unsigned       beats;
        int unsigned       results;
        int unsigned       data_bytes;
        int unsigned       b_opens;
        int unsigned       b_moves;

        function new();
            a_start    = 0;
            a_size     = 0;
            b_size     = 0;
            b_active   = 0;
            chunk_left = 0;
            chunk_ok   = 0;
            chunk_to_b = 0;
            errors     = 0;
            beats      = 0;
            results    = 0;
            data_bytes = 0;
            b_opens    = 0;
            b_moves    = 0;
        endfunction

        function int unsigned stored();
            return a_size + b_size;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // Space a chunk opened now would get.
        function int unsigned room();
            if (b_active)
                return a_start - b_size;
            if (STORE_BYTES - a_start - a_size < a_start)
                return a_start;
            return STORE_BYTES - a_start - a_size;
        endfunction

        function void post(bit st, logic [BYTE_W-1:0] d, bit dv, bit lst);
            t_store_result r;
            r.status     = st;
            r.data_out   = d;
            r.data_valid = dv;
            r.last       = lst;
            awaited.push_back(r);
        endfunction

        // Drop n oldest bytes; an emptied A takes over what is left of B.
        function void drop_bytes(int unsigned n);
            int unsigned from_a;
            int unsigned from_b;
            from_a  = (n > a_size) ? a_size : n;
            a_size -= from_a;
            a_start += from_a;
            n -= from_a;
            from_b  = (n > b_size) ? b_size : n;
            b_size -= from_b;
            if (a_size == 0) begin
                if (b_size > 0 && from_b > 0) begin
                    for (int i = 0; i < b_size; i++)
                        mem[i] = mem[i + from_b];
                    b_moves++;
                end
                a_size   = b_size;
                a_start  = 0;
                b_active = 0;
                b_size   = 0;
            end
        endfunction

        function void note_beat(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len_in,
                                logic [BYTE_W-1:0] din);
            int unsigned       len;
            int unsigned       avail;
            logic [BYTE_W-1:0] v;
            len   = len_in;
            avail = stored();
            beats++;
            if (kind == K_WRITE) begin
                if (chunk_left == 0) begin
                    if (len > CHUNK_MAX) begin
                        chunk_ok   = 0;
                        chunk_to_b = 0;
                        chunk_left = len - 1;
                        post(1'b1, '0, 1'b0, 1'b1);
                        return;
                    end
                    // B opens on the placement decision, even if the chunk is refused
                    if (!b_active && STORE_BYTES - a_start - a_size < a_start) begin
                        b_active = 1;
                        b_size   = 0;
                        b_opens++;
                    end
                    chunk_to_b = b_active;
                    chunk_ok   = (len <= room());
                    if (len == 0) begin
                        post(!chunk_ok, '0, 1'b0, 1'b1);
                        return;
                    end
                    chunk_left = len;
                end
                if (chunk_ok) begin
                    if (chunk_to_b) begin
                        mem[b_size] = din;
                        b_size++;
                    end else begin
                        mem[a_start + a_size] = din;
                        a_size++;
                    end
                end
                chunk_left = (chunk_left - 1) & 'h7F;
                post(!chunk_ok, '0, 1'b0, 1'b1);
                return;
            end
            // any command abandons an open chunk
            chunk_left = 0;
            if (kind == K_REMOVE) begin
                drop_bytes((len > avail) ? avail : len);
                post(1'b0, '0, 1'b0, 1'b1);
                return;
            end
            if (len > CHUNK_MAX || len > avail) begin
                post(1'b1, '0, 1'b0, 1'b1);
                return;
            end
            if (len == 0) begin
                if (kind == K_READ)
                    drop_bytes(0);
                post(1'b0, '0, 1'b0, 1'b1);
                return;
            end
            for (int unsigned k = 0; k < len; k++) begin
                v = (k < a_size) ? mem[a_start + k] : mem[k - a_size];
                post(1'b0, v, 1'b1, (k + 1 == len));
            end
            data_bytes += len;
            if (kind == K_READ)
                drop_bytes(len);
        endfunction

        function void check_result(logic st, logic [BYTE_W-1:0] d, logic dv, logic lst);
            t_store_result want;
            if (awaited.size() == 0) begin
                $error("result beat with nothing awaited: status %0d data_out 0x%02h last %0d",
                       st, d, lst);
                errors++;
                return;
            end
            want = awaited.pop_front();
            results++;
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (d !== want.data_out) begin
                $error("data_out: expected 0x%02h, actual 0x%02h", want.data_out, d);
                errors++;
            end
            if (dv !== want.data_valid) begin
                $error("data_valid: expected %0d, actual %0d", want.data_valid, dv);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, lst);
                errors++;
            end
        endfunction
    endclass

endpackage

/* tb/bip_buffer_byte_store_top_tb.sv */
// Self-checking testbench of the bip buffer byte store: directed corners, then random traffic.
module bip_buffer_byte_store_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bbs_pkg::*;
    import bip_store_check_pkg::*;

    // Generous bound on the length of the whole run.
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    // Worst tail after the last result: a B move of the whole store plus a full read.
    localparam int unsigned SETTLE_CYCLES = 2 * STORE_BYTES + 2 * CHUNK_MAX + 16;
    localparam int unsigned PHASE_BEATS   = 70;

    logic i_clk;
    logic i_rst_n;

    bbs_in_if  in_ch();
    bbs_out_if out_ch();

    bip_buffer_byte_store_top #(
        .CAPACITY (STORE_BYTES),
        .MAX_CHUNK(CHUNK_MAX)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    byte_store_scoreboard sb;
    int unsigned          src_idle_pct;
    int unsigned          sink_stall_pct;
    int unsigned          sent;
    int unsigned          cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: check every accepted beat, then pick next cycle's ready.
    // Values read here are the ones the block saw at this edge.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.status, out_ch.data_out, out_ch.data_valid,
                                out_ch.last);
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Hang guard.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // One input beat. Called at a clock edge; returns at the edge that took it.
    // valid stays high on return so back-to-back beats never drop it for a cycle;
    // each gap cycle makes exactly one assignment per edge.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input int unsigned len,
                             input logic [BYTE_W-1:0] data);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= kind;
        in_ch.length  <= len[LEN_W-1:0];
        in_ch.data_in <= data;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_beat(kind, len[LEN_W-1:0], data);
        sent++;
    endtask

    // Hold the sender off until every outstanding result beat has come back.
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // A write chunk: first beat carries len, later beats carry junk lengths
    // (ignored by the block). Only 'beats' of them go out; fewer than len abandons.
    task automatic send_chunk(input int unsigned len, input int unsigned beats);
        send_beat(K_WRITE, len, $urandom_range(255));
        for (int unsigned i = 1; i < beats; i++)
            send_beat(K_WRITE, $urandom_range(127), $urandom_range(255));
    endtask

    task automatic corner_cases();
        // empty store: zero read, peek refused, remove clamps to nothing
        send_beat(K_READ, 0, 8'h00);
        send_beat(K_PEEK, 1, 8'hFF);
        send_beat(K_REMOVE, 127, 8'h00);
        // zero-length chunk
        send_beat(K_WRITE, 0, 8'h5A);
        // three-byte chunk, extreme data values
        send_beat(K_WRITE, 3, 8'h00);
        send_beat(K_WRITE, 127, 8'hFF);
        send_beat(K_WRITE, 0, 8'hA5);
        // oversize chunk, two refused trailing bytes, then an oversize peek abandons it
        send_beat(K_WRITE, 127, 8'h11);
        send_beat(K_WRITE, 1, 8'h22);
        send_beat(K_WRITE, 64, 8'h33);
        send_beat(K_PEEK, 127, 8'h00);
        // chunk of five cut short after two bytes
        send_beat(K_WRITE, 5, 8'h81);
        send_beat(K_WRITE, 0, 8'h7E);
        send_beat(K_PEEK, 5, 8'h00);
        // oversize read, read of more than stored, then partial reads and remove
        send_beat(K_READ, 65, 8'h00);
        send_beat(K_READ, 6, 8'h00);
        send_beat(K_READ, 2, 8'h00);
        send_beat(K_REMOVE, 1, 8'h00);
        send_beat(K_PEEK, 2, 8'h00);
        send_beat(K_READ, 0, 8'h00);
        send_beat(K_REMOVE, 127, 8'h00);
        // largest legal chunk, abandoned after one byte by a read
        send_beat(K_WRITE, 64, 8'h3C);
        send_beat(K_READ, 1, 8'h00);
        send_beat(K_READ, 64, 8'h00);
    endtask

    // Random traffic: mostly whole chunks sized to the space left, with reads and
    // peeks sized to what is stored; a slice of refusals, cut chunks and oversize noise.
    task automatic random_traffic(input int unsigned n_beats);
        int unsigned       start_count;
        int unsigned       pick;
        int unsigned       roll;
        int unsigned       len;
        int unsigned       avail;
        int unsigned       space;
        int unsigned       beats;
        logic [KIND_W-1:0] kind;
        start_count = sent;
        while (sent - start_count < n_beats) begin
            pick  = $urandom_range(99);
            roll  = $urandom_range(99);
            avail = sb.stored();
            space = sb.room();
            if (pick < 45) begin
                if (roll < 4)
                    len = $urandom_range(127, CHUNK_MAX + 1);
                else if (roll < 8)
                    len = 0;
                else if (roll < 75 && space > 0)
                    len = $urandom_range((space < 40) ? space : 40, 1);
                else
                    len = $urandom_range(CHUNK_MAX, 1);
                if (len > CHUNK_MAX)
                    beats = $urandom_range(4, 1);
                else if ($urandom_range(19) == 0)
                    beats = $urandom_range(len);
                else
                    beats = len;
                send_chunk(len, (beats == 0) ? 1 : beats);
            end else if (pick < 85) begin
                kind = (pick < 70) ? K_READ : K_PEEK;
                if (roll < 5)
                    len = $urandom_range(127, CHUNK_MAX + 1);
                else if (roll < 10)
                    len = 0;
                else if (roll < 20)
                    len = avail + $urandom_range(8, 1);
                else
                    len = $urandom_range((avail < CHUNK_MAX) ? avail : CHUNK_MAX, 1);
                send_beat(kind, len, $urandom_range(255));
            end else begin
                len = (roll < 10) ? 127 : $urandom_range(avail + 4, 0);
                send_beat(K_REMOVE, (len > 127) ? 127 : len, $urandom_range(255));
            end
        end
    endtask

    initial begin
        sb             = new();
        sent           = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // every input known from time zero
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.kind     <= K_WRITE;
        in_ch.length   <= '0;
        in_ch.data_in  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        corner_cases();
        // sender waits for the pipe to empty at least once
        hold_until_drained();

        // idle mixes: none, sender gaps, receiver stalls, light both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 85;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 85;
                end
                default: begin
                    src_idle_pct   = 11;
                    sink_stall_pct = 11;
                end
            endcase
            random_traffic(PHASE_BEATS);
            hold_until_drained();
        end

        // stray results after the last expected one still get flagged
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d input beats, %0d result beats checked, %0d bytes read back",
                 sb.beats, sb.results, sb.data_bytes);
        $display("region B opened %0d times and was moved down %0d times; %0d mismatches",
                 sb.b_opens, sb.b_moves, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
